// ===== rtl/fbdm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Frame brightness difference meter package
// Shared item types, widths, scale constants and register indexes.
// ----------------------------------------------------------------------------
package fbdm_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int PC_W   = 25;
    localparam int BS_W   = 35;
    localparam int DS_W   = 42;
    localparam int BR_W   = 10;
    localparam int SQ_W   = 18;
    localparam int Q_W    = 20;
    localparam int MEGA_W = 20;
    localparam int BD_W   = PC_W + 10;
    localparam int DD_W   = PC_W + SQ_W;
    localparam int BP_W   = BS_W + MEGA_W;
    localparam int DP_W   = DS_W + MEGA_W;

    localparam logic [MEGA_W-1:0] MEGA    = MEGA_W'(1000000);
    localparam logic [9:0]        BR_FULL = 10'd765;
    localparam logic [SQ_W-1:0]   DF_FULL = SQ_W'(195075);

    localparam int QDEPTH = 2;
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam int CFG_IW = 2;
    localparam int CFG_DW = 18;
    localparam logic [CFG_IW-1:0] CFG_SAMPLE_STEP    = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_SAMPLE_OFFSET  = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_DIFF_THRESHOLD = 2'd2;

    localparam logic [7:0]      STEP_RST   = 8'd10;
    localparam logic [7:0]      OFFSET_RST = 8'd5;
    localparam logic [SQ_W-1:0] THRESH_RST = SQ_W'(14630);

    typedef struct packed {
        logic [7:0] cur_red;
        logic [7:0] cur_green;
        logic [7:0] cur_blue;
        logic [7:0] prev_red;
        logic [7:0] prev_green;
        logic [7:0] prev_blue;
        logic       end_of_row;
        logic       end_of_frame;
    } t_fbdm_item;

    typedef struct packed {
        logic [Q_W-1:0] brightness_ppm;
        logic [Q_W-1:0] difference_ppm;
        logic           no_samples;
    } t_fbdm_res;

    typedef struct packed {
        logic [PC_W-1:0] point_count;
        logic [BS_W-1:0] brightness_sum;
        logic [DS_W-1:0] difference_sum;
    } t_fbdm_snap;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_fbdm_state;

endpackage
`default_nettype wire

// ===== rtl/frame_brightness_difference_meter_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Frame brightness difference meter
// Samples a grid of pixel pairs per frame and reports mean brightness and mean
// thresholded squared difference in millionths of full scale.
// ----------------------------------------------------------------------------
// Throughput: one pixel pair per cycle; full rises only while the two-entry
//   snapshot queue, counting a snapshot being written, holds two frame results.
// Flow: an end-of-frame item passes the front stage register and the snapshot queue,
//   then shift-add scaling and bit-serial division; scaling and division are skipped
//   when no position was sampled. The back end holds one result until it is popped.
// Reset: synchronous, active low; control and config registers return to reset values, sums clear.
// ----------------------------------------------------------------------------
module frame_brightness_difference_meter_top
    import fbdm_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire t_fbdm_item        i_item,
    output logic                   empty,
    input  wire logic              pop,
    output t_fbdm_res              o_item,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CFG_IW-1:0] i_cfg_index,
    input  wire logic [CFG_DW-1:0] i_cfg_data
);

    logic             accept;
    logic             f_push;
    t_fbdm_snap       f_snap;
    t_fbdm_snap       q_head;
    logic             q_empty;
    logic [QCW-1:0]   q_count;
    logic             q_pop;

    assign cfg_ready = 1'b1;
    assign full      = (({1'b0, q_count} + (QCW + 1)'(f_push)) >= (QCW + 1)'(QDEPTH));
    assign accept    = push && !full;

    fbdm_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .i_cfg_we    (cfg_valid && cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_push      (f_push),
        .o_snap      (f_snap)
    );

    fbdm_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_snap  (f_snap),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    fbdm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap       (q_head),
        .i_snap_empty (q_empty),
        .o_snap_pop   (q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_res        (o_item)
    );

endmodule
`default_nettype wire

// ===== rtl/fbdm_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Frame brightness difference meter: front end
// Sampling schedule, per-pixel squares and running sums; frame totals are
// pushed as a snapshot at end of frame.
// ----------------------------------------------------------------------------
module fbdm_front
    import fbdm_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire t_fbdm_item        i_item,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_IW-1:0] i_cfg_index,
    input  wire logic [CFG_DW-1:0] i_cfg_data,
    output logic                   o_push,
    output t_fbdm_snap             o_snap
);

    localparam int CW  = $clog2(MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 1);
    localparam int NCW = (CW > 8) ? CW : 8;
    localparam int NRW = (RW > 8) ? RW : 8;

    logic [7:0]      r_step;
    logic [7:0]      r_offset;
    logic [SQ_W-1:0] r_thresh;

    logic [CW-1:0]   r_col;
    logic [RW-1:0]   r_row;
    logic [NCW-1:0]  r_nsc;
    logic [NRW-1:0]  r_nsr;

    logic            r_s1_valid;
    logic            r_s1_smp;
    logic            r_s1_eof;
    logic [BR_W-1:0] r_s1_br;
    logic [SQ_W-1:0] r_s1_d;

    logic [PC_W-1:0] r_pc;
    logic [BS_W-1:0] r_bs;
    logic [DS_W-1:0] r_ds;

    logic            row_hit;
    logic            col_hit;
    logic [NCW:0]    nsc_sum;
    logic [NRW:0]    nsr_sum;
    logic [NCW-1:0]  nsc_adv;
    logic [NRW-1:0]  nsr_adv;
    logic [CW-1:0]   col_inc;
    logic [RW-1:0]   row_inc;
    logic [SQ_W-1:0] d_sum;
    logic            take;
    logic [DS_W:0]   ds_sum;
    logic [PC_W-1:0] n_pc;
    logic [BS_W-1:0] n_bs;
    logic [DS_W-1:0] n_ds;

    function automatic logic [15:0] sq_abs(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] m;
        m = (a >= b) ? (a - b) : (b - a);
        return 16'(m) * 16'(m);
    endfunction

    always_comb begin
        row_hit = (r_row < RW'(MAX_HEIGHT)) && (NRW'(r_row) == r_nsr);
        col_hit = row_hit && (r_col < CW'(MAX_WIDTH)) && (NCW'(r_col) == r_nsc);
        nsc_sum = (NCW + 1)'(r_nsc) + (NCW + 1)'(r_step);
        nsr_sum = (NRW + 1)'(r_nsr) + (NRW + 1)'(r_step);
        nsc_adv = (nsc_sum > (NCW + 1)'(MAX_WIDTH)) ? NCW'(MAX_WIDTH) : NCW'(nsc_sum);
        nsr_adv = (nsr_sum > (NRW + 1)'(MAX_HEIGHT)) ? NRW'(MAX_HEIGHT) : NRW'(nsr_sum);
        col_inc = (r_col == CW'(MAX_WIDTH)) ? r_col : r_col + 1'b1;
        row_inc = (r_row == RW'(MAX_HEIGHT)) ? r_row : r_row + 1'b1;
        d_sum   = SQ_W'(sq_abs(i_item.cur_red, i_item.prev_red))
                + SQ_W'(sq_abs(i_item.cur_green, i_item.prev_green))
                + SQ_W'(sq_abs(i_item.cur_blue, i_item.prev_blue));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= STEP_RST;
            r_offset <= OFFSET_RST;
            r_thresh <= THRESH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SAMPLE_STEP:    r_step   <= i_cfg_data[7:0];
                CFG_SAMPLE_OFFSET:  r_offset <= i_cfg_data[7:0];
                CFG_DIFF_THRESHOLD: r_thresh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_nsc      <= NCW'(OFFSET_RST);
            r_nsr      <= NRW'(OFFSET_RST);
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_accept;
            if (i_accept) begin
                if (i_item.end_of_frame) begin
                    r_col <= '0;
                    r_row <= '0;
                    r_nsc <= NCW'(r_offset);
                    r_nsr <= NRW'(r_offset);
                end else if (i_item.end_of_row) begin
                    r_col <= '0;
                    r_row <= row_inc;
                    r_nsc <= NCW'(r_offset);
                    if (row_hit) begin
                        r_nsr <= nsr_adv;
                    end
                end else begin
                    r_col <= col_inc;
                    if (col_hit) begin
                        r_nsc <= nsc_adv;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_smp <= col_hit;
            r_s1_eof <= i_item.end_of_frame;
            r_s1_br  <= BR_W'(i_item.cur_red) + BR_W'(i_item.cur_green)
                      + BR_W'(i_item.cur_blue);
            r_s1_d   <= (d_sum > r_thresh) ? d_sum : '0;
        end
    end

    always_comb begin
        take   = r_s1_smp && (r_pc != '1);
        ds_sum = (DS_W + 1)'(r_ds) + (DS_W + 1)'(r_s1_d);
        n_pc   = take ? r_pc + 1'b1 : r_pc;
        n_bs   = take ? r_bs + BS_W'(r_s1_br) : r_bs;
        n_ds   = !take ? r_ds : (ds_sum[DS_W] ? '1 : ds_sum[DS_W-1:0]);
        o_push = r_s1_valid && r_s1_eof;
        o_snap = '{point_count: n_pc, brightness_sum: n_bs, difference_sum: n_ds};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
            r_bs <= '0;
            r_ds <= '0;
        end else if (r_s1_valid) begin
            if (r_s1_eof) begin
                r_pc <= '0;
                r_bs <= '0;
                r_ds <= '0;
            end else begin
                r_pc <= n_pc;
                r_bs <= n_bs;
                r_ds <= n_ds;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/fbdm_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Frame brightness difference meter: snapshot queue
// Short register queue of frame totals between front and back end.
// ----------------------------------------------------------------------------
module fbdm_queue
    import fbdm_pkg::*;
#(
    parameter int DEPTH = QDEPTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire t_fbdm_snap                 i_snap,
    input  wire logic                       i_pop,
    output t_fbdm_snap                      o_head,
    output logic                            o_empty,
    output logic [$clog2(DEPTH + 1)-1:0]    o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_fbdm_snap     r_mem [DEPTH];
    logic [PW-1:0]  r_wptr;
    logic [PW-1:0]  r_rptr;
    logic [CW-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_snap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
        end
    end

    assign o_head  = r_mem[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < CW'(DEPTH)))
        else $error("snapshot queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("snapshot queue underflow");
`endif

endmodule
`default_nettype wire

// ===== rtl/fbdm_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Frame brightness difference meter: back end
// Scales frame totals by one million with a serial shift-add and divides by
// full scale times point count with a restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module fbdm_back
    import fbdm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_fbdm_snap i_snap,
    input  wire logic       i_snap_empty,
    output logic            o_snap_pop,
    input  wire logic       i_pop,
    output logic            o_empty,
    output t_fbdm_res       o_res
);

    localparam int CNT_W = $clog2(MEGA_W > Q_W ? MEGA_W : Q_W);

    t_fbdm_state       r_state;
    t_fbdm_state       n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [MEGA_W-1:0] r_mk;
    logic [BP_W-1:0]   r_sb;
    logic [DP_W-1:0]   r_sd;
    logic [BP_W-1:0]   r_pb;
    logic [DP_W-1:0]   r_pd;
    logic [BD_W-1:0]   r_db;
    logic [DD_W-1:0]   r_dd;
    logic [BP_W-1:0]   r_vb;
    logic [DP_W-1:0]   r_vd;
    logic [Q_W-1:0]    r_qb;
    logic [Q_W-1:0]    r_qd;
    logic              r_ns;
    logic              ge_b;
    logic              ge_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_snap_pop = 1'b0;
        o_empty    = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_snap_empty) begin
                    o_snap_pop = 1'b1;
                    n_state    = (i_snap.point_count == '0) ? ST_DONE : ST_MUL;
                end
            end
            ST_MUL: begin
                if (r_cnt == CNT_W'(MEGA_W - 1)) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == CNT_W'(Q_W - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_empty = 1'b0;
                if (i_pop) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign ge_b = (r_pb >= r_vb);
    assign ge_d = (r_pd >= r_vd);

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_cnt <= '0;
                r_mk  <= MEGA;
                r_sb  <= BP_W'(i_snap.brightness_sum);
                r_sd  <= DP_W'(i_snap.difference_sum);
                r_pb  <= '0;
                r_pd  <= '0;
                r_db  <= BD_W'(i_snap.point_count) * BD_W'(BR_FULL);
                r_dd  <= DD_W'(i_snap.point_count) * DD_W'(DF_FULL);
                r_qb  <= '0;
                r_qd  <= '0;
                r_ns  <= (i_snap.point_count == '0);
            end
            ST_MUL: begin
                if (r_mk[0]) begin
                    r_pb <= r_pb + r_sb;
                    r_pd <= r_pd + r_sd;
                end
                r_sb <= r_sb << 1;
                r_sd <= r_sd << 1;
                r_mk <= r_mk >> 1;
                r_vb <= BP_W'(r_db) << (Q_W - 1);
                r_vd <= DP_W'(r_dd) << (Q_W - 1);
                r_cnt <= (r_cnt == CNT_W'(MEGA_W - 1)) ? '0 : r_cnt + 1'b1;
            end
            ST_DIV: begin
                if (ge_b) begin
                    r_pb <= r_pb - r_vb;
                end
                if (ge_d) begin
                    r_pd <= r_pd - r_vd;
                end
                r_qb  <= {r_qb[Q_W-2:0], ge_b};
                r_qd  <= {r_qd[Q_W-2:0], ge_d};
                r_vb  <= r_vb >> 1;
                r_vd  <= r_vd >> 1;
                r_cnt <= r_cnt + 1'b1;
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    assign o_res = '{brightness_ppm: r_qb, difference_ppm: r_qd, no_samples: r_ns};

`ifndef SYNTH
    a_empty_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_res.no_samples) |->
            (o_res.brightness_ppm == '0 && o_res.difference_ppm == '0))
        else $error("empty frame gave non-zero result");
    a_ppm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_res.brightness_ppm <= Q_W'(MEGA) &&
                      o_res.difference_ppm <= Q_W'(MEGA)))
        else $error("result above full scale");
    a_pop_idle_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_snap_pop |=> (r_state == ST_MUL || r_state == ST_DONE))
        else $error("snapshot taken outside idle");
`endif

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame brightness difference meter testbench
// Streams pixel pairs from a queue under random push and pop idling, predicts
// each frame result from a local model of the sampling grid and the sums,
// and checks every popped result field by field. Covers register extremes,
// offset changes mid-frame and a long output stall that backs the block up.
// ----------------------------------------------------------------------------
module tb;
    import fbdm_pkg::*;

    localparam int COL_LIMIT = MAX_WIDTH_DEF;
    localparam int ROW_LIMIT = MAX_HEIGHT_DEF;
    localparam logic [PC_W-1:0] POINT_FULL = '1;
    localparam logic [DS_W-1:0] DSUM_FULL  = '1;
    localparam logic [CFG_IW-1:0] CFG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 80;
    localparam int STALL_LIMIT   = 10000;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 180;

    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              push      = 1'b0;
    logic              full;
    t_fbdm_item        pix_in    = '0;
    logic              empty;
    logic              pop       = 1'b0;
    t_fbdm_res         meter_out;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [CFG_DW-1:0] cfg_data  = '0;

    frame_brightness_difference_meter_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (pix_in),
        .empty       (empty),
        .pop         (pop),
        .o_item      (meter_out),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // register shadow
    logic [7:0]      step_cfg   = STEP_RST;
    logic [7:0]      offset_cfg = OFFSET_RST;
    logic [SQ_W-1:0] thresh_cfg = THRESH_RST;

    // predicted frame state
    logic [12:0]     col_idx    = '0;
    logic [12:0]     next_col   = 13'(OFFSET_RST);
    logic [12:0]     row_idx    = '0;
    logic [12:0]     next_row   = 13'(OFFSET_RST);
    logic [PC_W-1:0] n_points   = '0;
    logic [BS_W-1:0] bright_sum = '0;
    logic [DS_W-1:0] diff_sum   = '0;

    t_fbdm_item pixel_q[$];
    t_fbdm_res  meter_q[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req      = 0;
    int hold_ack      = 0;
    int hold_left     = 0;
    int stall_cnt     = 0;
    int n_pixels      = 0;
    int n_results     = 0;
    int n_writes      = 0;
    int n_errors      = 0;

    function automatic logic [12:0] sat_lim(int unsigned a, int unsigned lim);
        return (a > lim) ? 13'(lim) : 13'(a);
    endfunction

    function automatic int unsigned sq_gap(logic [7:0] a, logic [7:0] b);
        int unsigned g;
        g = (a >= b) ? 32'(a) - 32'(b) : 32'(b) - 32'(a);
        return g * g;
    endfunction

    task automatic clear_frame_state();
        col_idx    = '0;
        row_idx    = '0;
        next_col   = 13'(offset_cfg);
        next_row   = 13'(offset_cfg);
        n_points   = '0;
        bright_sum = '0;
        diff_sum   = '0;
    endtask

    task automatic predict_pixel(input t_fbdm_item px);
        logic            row_hit;
        int unsigned     gap2;
        longint unsigned acc;
        longint unsigned den;
        t_fbdm_res       r;
        row_hit = (row_idx < ROW_LIMIT) && (row_idx == next_row);
        if (row_hit && col_idx < COL_LIMIT && col_idx == next_col) begin
            next_col = sat_lim(32'(next_col) + 32'(step_cfg), COL_LIMIT);
            if (n_points < POINT_FULL) begin
                gap2 = sq_gap(px.cur_red, px.prev_red) + sq_gap(px.cur_green, px.prev_green)
                     + sq_gap(px.cur_blue, px.prev_blue);
                n_points   = n_points + 1'b1;
                bright_sum = bright_sum + BS_W'(px.cur_red) + BS_W'(px.cur_green)
                           + BS_W'(px.cur_blue);
                if (gap2 > 32'(thresh_cfg)) begin
                    acc      = 64'(diff_sum) + 64'(gap2);
                    diff_sum = (acc > 64'(DSUM_FULL)) ? DSUM_FULL : DS_W'(acc);
                end
            end
        end
        col_idx = sat_lim(32'(col_idx) + 32'd1, COL_LIMIT);
        if (px.end_of_frame) begin
            r = '0;
            if (n_points == 0) begin
                r.no_samples = 1'b1;
            end else begin
                den = 64'(n_points) * 64'd765;
                r.brightness_ppm = Q_W'((64'(bright_sum) * 64'd1000000) / den);
                den = 64'(n_points) * 64'd195075;
                r.difference_ppm = Q_W'((64'(diff_sum) * 64'd1000000) / den);
            end
            meter_q.push_back(r);
            clear_frame_state();
        end else if (px.end_of_row) begin
            if (row_hit)
                next_row = sat_lim(32'(next_row) + 32'(step_cfg), ROW_LIMIT);
            row_idx  = sat_lim(32'(row_idx) + 32'd1, ROW_LIMIT);
            col_idx  = '0;
            next_col = 13'(offset_cfg);
        end
    endtask

    function automatic t_fbdm_item pixel(logic [7:0] cr, logic [7:0] cg, logic [7:0] cb,
                                         logic [7:0] pr, logic [7:0] pg, logic [7:0] pb,
                                         logic eor, logic eof);
        t_fbdm_item p;
        p.cur_red      = cr;
        p.cur_green    = cg;
        p.cur_blue     = cb;
        p.prev_red     = pr;
        p.prev_green   = pg;
        p.prev_blue    = pb;
        p.end_of_row   = eor;
        p.end_of_frame = eof;
        return p;
    endfunction

    function automatic t_fbdm_item rand_pixel(logic eor, logic eof);
        t_fbdm_item p;
        p.cur_red   = 8'($urandom);
        p.cur_green = 8'($urandom);
        p.cur_blue  = 8'($urandom);
        case ($urandom_range(3))
            0: begin
                p.prev_red   = p.cur_red ^ 8'($urandom_range(15));
                p.prev_green = p.cur_green ^ 8'($urandom_range(15));
                p.prev_blue  = p.cur_blue ^ 8'($urandom_range(15));
            end
            1: begin
                p.cur_red    = $urandom_range(1) ? 8'hFF : 8'h00;
                p.cur_green  = $urandom_range(1) ? 8'hFF : 8'h00;
                p.cur_blue   = $urandom_range(1) ? 8'hFF : 8'h00;
                p.prev_red   = ~p.cur_red;
                p.prev_green = ~p.cur_green;
                p.prev_blue  = ~p.cur_blue;
            end
            default: begin
                p.prev_red   = 8'($urandom);
                p.prev_green = 8'($urandom);
                p.prev_blue  = 8'($urandom);
            end
        endcase
        p.end_of_row   = eor;
        p.end_of_frame = eof;
        return p;
    endfunction

    // mostly whole frames of random size, some bursts of loose markers
    task automatic queue_random_traffic(int n);
        int   added;
        int   rows;
        int   len;
        logic last;
        logic endf;
        added = 0;
        while (added < n) begin
            if ($urandom_range(99) < 15) begin
                len = $urandom_range(1, 10);
                repeat (len)
                    pixel_q.push_back(rand_pixel($urandom_range(99) < 25,
                                                 $urandom_range(99) < 5));
                added += len;
            end else begin
                rows = $urandom_range(1, 6);
                for (int r = 0; r < rows; r++) begin
                    len = $urandom_range(1, 8);
                    for (int c = 0; c < len; c++) begin
                        last = (c == len - 1);
                        endf = last && (r == rows - 1);
                        pixel_q.push_back(rand_pixel(last && (!endf || $urandom_range(1)),
                                                     endf));
                    end
                    added += len;
                end
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SAMPLE_STEP:    step_cfg   = val[7:0];
            CFG_SAMPLE_OFFSET:  offset_cfg = val[7:0];
            CFG_DIFF_THRESHOLD: thresh_cfg = val;
            default: ;
        endcase
        n_writes++;
    endtask

    // upper data bits above the 8-bit fields carry junk
    task automatic set_meter(logic [7:0] step, logic [7:0] offset, logic [SQ_W-1:0] thresh);
        write_reg(CFG_SAMPLE_STEP, {10'($urandom), step});
        write_reg(CFG_SAMPLE_OFFSET, {10'($urandom), offset});
        write_reg(CFG_DIFF_THRESHOLD, thresh);
    endtask

    task automatic wait_idle();
        while (pixel_q.size() != 0 || push || meter_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : pixel_driver
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                predict_pixel(pix_in);
                void'(pixel_q.pop_front());
                n_pixels++;
            end
            if (!(push && full)) begin
                if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    push   <= 1'b1;
                    pix_in <= pixel_q[0];
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_fbdm_res want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                n_results++;
                if (meter_q.size() == 0) begin
                    $error("result popped with none expected");
                    n_errors++;
                end else begin
                    want = meter_q.pop_front();
                    if (meter_out.brightness_ppm !== want.brightness_ppm) begin
                        $error("brightness_ppm expected %0d actual %0d",
                               want.brightness_ppm, meter_out.brightness_ppm);
                        n_errors++;
                    end
                    if (meter_out.difference_ppm !== want.difference_ppm) begin
                        $error("difference_ppm expected %0d actual %0d",
                               want.difference_ppm, meter_out.difference_ppm);
                        n_errors++;
                    end
                    if (meter_out.no_samples !== want.no_samples) begin
                        $error("no_samples expected %0d actual %0d",
                               want.no_samples, meter_out.no_samples);
                        n_errors++;
                    end
                end
            end
            if (hold_ack != hold_req) begin
                hold_ack  = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : stall_watch
        if (!i_rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 9;
        recv_idle_pct = 57;

        // reset settings, single pixel frame: nothing sampled
        @(negedge i_clk);
        pixel_q.push_back(pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1));
        wait_idle();

        // every pixel sampled, zero threshold, frame ends mid-row
        set_meter(8'd1, 8'd0, '0);
        @(negedge i_clk);
        pixel_q.push_back(pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
        pixel_q.push_back(pixel(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0));
        pixel_q.push_back(pixel(8'd128, 8'd64, 8'd32, 8'd128, 8'd64, 8'd32, 1'b0, 1'b0));
        pixel_q.push_back(pixel(8'd1, 8'd2, 8'd3, 8'd200, 8'd100, 8'd50, 1'b0, 1'b1));
        wait_idle();

        // threshold at full scale blocks the largest difference
        write_reg(CFG_DIFF_THRESHOLD, SQ_W'(195075));
        @(negedge i_clk);
        pixel_q.push_back(pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
        pixel_q.push_back(pixel(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
        wait_idle();
        write_reg(CFG_DIFF_THRESHOLD, SQ_W'(195074));
        @(negedge i_clk);
        pixel_q.push_back(pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1));
        wait_idle();

        // zero step, offset changed between rows of one frame
        set_meter(8'd0, 8'd1, SQ_W'(100));
        @(negedge i_clk);
        for (int c = 0; c < 3; c++)
            pixel_q.push_back(rand_pixel(c == 2, 1'b0));
        wait_idle();
        write_reg(CFG_SAMPLE_OFFSET, 18'd0);
        @(negedge i_clk);
        for (int c = 0; c < 6; c++)
            pixel_q.push_back(rand_pixel(c == 2 || c == 5, c == 5));
        wait_idle();

        // offset beyond the frame, top threshold code
        set_meter(8'd3, 8'd255, '1);
        @(negedge i_clk);
        pixel_q.push_back(rand_pixel(1'b0, 1'b0));
        pixel_q.push_back(rand_pixel(1'b1, 1'b1));
        wait_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph < 3) begin
                send_idle_pct = 9;
                recv_idle_pct = 57;
            end else if (ph < 6) begin
                send_idle_pct = 57;
                recv_idle_pct = 9;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_idle();
            case (ph)
                0: set_meter(8'd1, 8'd0, SQ_W'($urandom_range(40000)));
                1: set_meter(8'd2, 8'd1, '0);
                2: set_meter(8'd255, 8'd255, SQ_W'(195075));
                3: set_meter(8'd0, 8'd2, SQ_W'($urandom_range(40000)));
                4: set_meter(8'd3, 8'd0, '1);
                default: set_meter(8'($urandom_range(1, 4)), 8'($urandom_range(3)),
                                   SQ_W'($urandom_range(40000)));
            endcase
            if (ph == 4)
                write_reg(CFG_UNUSED, CFG_DW'($urandom));
            @(negedge i_clk);
            if (ph == 6) begin
                // output held off while single-pixel frames keep coming
                hold_req++;
                repeat (12) pixel_q.push_back(rand_pixel(1'($urandom_range(1)), 1'b1));
            end
            queue_random_traffic(PHASE_ITEMS);
        end

        wait_idle();
        $display("covered %0d pixel items, %0d frame results, %0d register writes",
                 n_pixels, n_results, n_writes);
        $display("incl. step/offset/threshold extremes, mid-frame offset change, output stall");
        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/fbdm_pkg.sv
rtl/fbdm_front.sv
rtl/fbdm_queue.sv
rtl/fbdm_back.sv
rtl/frame_brightness_difference_meter_top.sv
verif/tb.sv
